[hw/rtl/saw_pkg.sv]
// ----------------------------------------------------------------------------
// saw_pkg
// Shared types, constants and the letter classifier for the sliding window
// anagram counter.
// ----------------------------------------------------------------------------
package saw_pkg;

  localparam int WINDOW_MAX_DEF = 4096;
  localparam int ALPHABET_SIZE  = 52;
  localparam int LOWER_COUNT    = 26;
  localparam int SLOT_W         = 6;
  localparam int CHAR_W         = 8;
  localparam int LEN_W          = 13;
  localparam int HIST_W         = 13;
  localparam int COUNT_W        = 24;
  localparam int MID_DEPTH      = 2;
  localparam int OUT_DEPTH      = 4;

  localparam logic [HIST_W-1:0]  HIST_MAX  = '1;
  localparam logic [LEN_W-1:0]   SEEN_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CHAR_W-1:0] CH_LC_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UC_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_Z = 8'h5a;

  typedef enum logic [1:0] {
    KIND_PATTERN = 2'd0,
    KIND_TEXT    = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_e;

  // what the back end has to do with an item
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PATTERN,
    OP_TEXT,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic               window_full;
    logic               is_match;
    logic [COUNT_W-1:0] match_count;
  } res_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] idx;
  } slot_t;

  typedef struct packed {
    op_e               op;
    slot_t             slot;
    logic [CHAR_W-1:0] char_byte;
  } op_item_t;

  typedef struct packed {
    logic              clear;
    logic              pat_en;
    logic              win_dec;
    logic              win_inc;
    logic [SLOT_W-1:0] inc_idx;
    logic [SLOT_W-1:0] dec_idx;
  } hist_op_t;

  // a..z to 0..25, A..Z to 26..51, anything else has no slot
  function automatic slot_t letter_slot(logic [CHAR_W-1:0] b);
    slot_t s;
    s.valid = 1'b1;
    s.idx   = '0;
    if (b >= CH_LC_A && b <= CH_LC_Z) begin
      s.idx = SLOT_W'(b - CH_LC_A);
    end else if (b >= CH_UC_A && b <= CH_UC_Z) begin
      s.idx = SLOT_W'(b - CH_UC_A) + SLOT_W'(LOWER_COUNT);
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

[hw/rtl/saw_fifo.sv]
// ----------------------------------------------------------------------------
// saw_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module saw_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  item_t                        data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output item_t                        data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  item_t          mem_q [DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/saw_front.sv]
// ----------------------------------------------------------------------------
// saw_front
// Accepts input items, classifies kind and letter, and queues them for the
// back end.
// ----------------------------------------------------------------------------
module saw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  saw_pkg::in_item_t in_item_i,
  output logic              full,
  input  logic              mid_pop_i,
  output saw_pkg::op_item_t mid_item_o,
  output logic              mid_empty_o
);

  import saw_pkg::*;

  op_item_t cls;
  slot_t    slot;

  assign slot = letter_slot(in_item_i.char_byte);

  always_comb begin
    cls.slot      = slot;
    cls.char_byte = in_item_i.char_byte;
    unique case (in_item_i.kind)
      KIND_PATTERN: cls.op = slot.valid ? OP_PATTERN : OP_NONE;
      KIND_TEXT:    cls.op = OP_TEXT;
      KIND_CLEAR:   cls.op = OP_CLEAR;
      default:      cls.op = OP_NONE;
    endcase
  end

  saw_fifo #(
    .item_t (op_item_t),
    .DEPTH  (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls),
    .full_o  (full),
    .pop_i   (mid_pop_i),
    .data_o  (mid_item_o),
    .empty_o (mid_empty_o),
    .count_o ()
  );

endmodule

[hw/rtl/saw_hist.sv]
// ----------------------------------------------------------------------------
// saw_hist
// Row of 52 letter cells, each with a pattern and a window count, and the
// equality of both histograms after the update.
// ----------------------------------------------------------------------------
module saw_hist (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  saw_pkg::hist_op_t op_i,
  output logic              all_eq_o
);

  import saw_pkg::*;

  logic [HIST_W-1:0]        pat_q [ALPHABET_SIZE];
  logic [HIST_W-1:0]        pat_d [ALPHABET_SIZE];
  logic [HIST_W-1:0]        win_q [ALPHABET_SIZE];
  logic [HIST_W-1:0]        win_m [ALPHABET_SIZE];
  logic [HIST_W-1:0]        win_d [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] eq_d;

  always_comb begin
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      pat_d[i] = pat_q[i];
      if (op_i.pat_en && op_i.inc_idx == SLOT_W'(i) && pat_q[i] != HIST_MAX) begin
        pat_d[i] = pat_q[i] + 1'b1;
      end
      // leaving byte comes out before the entering byte goes in
      win_m[i] = win_q[i];
      if (op_i.win_dec && op_i.dec_idx == SLOT_W'(i) && win_q[i] != '0) begin
        win_m[i] = win_q[i] - 1'b1;
      end
      win_d[i] = win_m[i];
      if (op_i.win_inc && op_i.inc_idx == SLOT_W'(i) && win_m[i] != HIST_MAX) begin
        win_d[i] = win_m[i] + 1'b1;
      end
      if (op_i.clear) begin
        pat_d[i] = '0;
        win_d[i] = '0;
      end
      eq_d[i] = (pat_d[i] == win_d[i]);
    end
  end

  assign all_eq_o = &eq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        pat_q[i] <= '0;
        win_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        pat_q[i] <= pat_d[i];
        win_q[i] <= win_d[i];
      end
    end
  end

endmodule

[hw/rtl/saw_back.sv]
// ----------------------------------------------------------------------------
// saw_back
// Executes classified items: ring store and text counters in the first
// stage, histogram update and match count in the second, then a result queue.
// ----------------------------------------------------------------------------
module saw_back #(
  parameter int WINDOW_MAX = saw_pkg::WINDOW_MAX_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [saw_pkg::LEN_W-1:0] len_i,
  input  saw_pkg::op_item_t        mid_item_i,
  input  logic                     mid_empty_i,
  output logic                     mid_pop_o,
  input  logic                     pop,
  output logic                     empty,
  output saw_pkg::res_t            res_o
);

  import saw_pkg::*;

  localparam int RING_AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int DIFF_W  = ((RING_AW > LEN_W) ? RING_AW : LEN_W) + 1;
  localparam int OCW     = $clog2(OUT_DEPTH+1);

  // stage a
  logic [RING_AW-1:0] pos_q, pos_d;
  logic [LEN_W-1:0]   seen_q, seen_d, seen_inc;
  logic [DIFF_W-1:0]  diff;
  logic [RING_AW-1:0] old_idx;
  logic               leave_a, full_a;
  logic [CHAR_W-1:0]  ring_q [WINDOW_MAX];

  // stage b
  logic               b_valid_q;
  op_item_t           b_item_q;
  logic               b_leave_q, b_full_q;
  logic [CHAR_W-1:0]  old_byte_q;
  slot_t              old_slot;
  hist_op_t           hop;
  logic               all_eq, match;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  res_t               res_d;

  // result queue
  logic               out_full;
  logic [OCW-1:0]     out_cnt;
  logic [OCW:0]       out_used;
  logic               room;

  // only issue when the result queue can take everything in flight
  assign out_used  = (OCW+1)'(out_cnt) + (OCW+1)'(b_valid_q);
  assign room      = out_used < (OCW+1)'(OUT_DEPTH);
  assign mid_pop_o = !mid_empty_i && room;

  always_comb begin
    leave_a  = (seen_q >= len_i);
    seen_inc = (seen_q == SEEN_MAX) ? seen_q : seen_q + 1'b1;
    diff     = DIFF_W'(pos_q) - DIFF_W'(len_i);
    old_idx  = diff[DIFF_W-1] ? RING_AW'(diff + DIFF_W'(WINDOW_MAX)) : RING_AW'(diff);
    pos_d    = pos_q;
    seen_d   = seen_q;
    full_a   = leave_a;
    case (mid_item_i.op)
      OP_TEXT: begin
        pos_d  = (pos_q == RING_AW'(WINDOW_MAX-1)) ? '0 : pos_q + 1'b1;
        seen_d = seen_inc;
        full_a = (seen_inc >= len_i);
      end
      OP_CLEAR: begin
        pos_d  = '0;
        seen_d = '0;
        full_a = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      seen_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= mid_pop_o;
      if (mid_pop_o) begin
        pos_q  <= pos_d;
        seen_q <= seen_d;
      end
    end
  end

  // ring store, read before write in the same cycle
  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      old_byte_q <= ring_q[old_idx];
      if (mid_item_i.op == OP_TEXT) begin
        ring_q[pos_q] <= mid_item_i.char_byte;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      b_item_q  <= mid_item_i;
      b_leave_q <= leave_a;
      b_full_q  <= full_a;
    end
  end

  assign old_slot = letter_slot(old_byte_q);

  always_comb begin
    hop.clear   = b_valid_q && (b_item_q.op == OP_CLEAR);
    hop.pat_en  = b_valid_q && (b_item_q.op == OP_PATTERN);
    hop.win_dec = b_valid_q && (b_item_q.op == OP_TEXT) && b_leave_q && old_slot.valid;
    hop.win_inc = b_valid_q && (b_item_q.op == OP_TEXT) && b_item_q.slot.valid;
    hop.inc_idx = b_item_q.slot.idx;
    hop.dec_idx = old_slot.idx;
  end

  saw_hist u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (hop),
    .all_eq_o (all_eq)
  );

  assign match = b_valid_q && (b_item_q.op == OP_TEXT) && b_full_q && all_eq;

  always_comb begin
    cnt_d = cnt_q;
    if (hop.clear) begin
      cnt_d = '0;
    end else if (match && cnt_q != COUNT_MAX) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (hop.clear) begin
      res_d = '0;
    end else begin
      res_d.window_full = b_full_q;
      res_d.is_match    = match;
      res_d.match_count = cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  saw_fifo #(
    .item_t (res_t),
    .DEPTH  (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_valid_q),
    .data_i  (res_d),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (res_o),
    .empty_o (empty),
    .count_o (out_cnt)
  );

  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> !out_full)
    else $error("result queue overrun");

  a_clear_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_pop_o && mid_item_i.op == OP_CLEAR) |=> (seen_q == '0 && pos_q == '0))
    else $error("clear left text position");

  a_match_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && res_d.is_match) |-> res_d.window_full)
    else $error("match reported on a partial window");

  a_clear_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_item_q.op == OP_CLEAR) |=> (cnt_q == '0))
    else $error("clear left match count");

endmodule

[hw/rtl/sliding_anagram_window_counter_top.sv]
// path: an item passes the item queue, the stage b registers and the result queue to the result ports
// throughput: one item per cycle while the result queue has room, the text update is one stage of histogram cells
// a stalled result side fills the 4-entry result queue, then the 2-entry item queue
// reset: asynchronous, clears histograms, counters, queues and window_length to 1
// the ring store contents stay undefined after reset and need no clearing pass
// ----------------------------------------------------------------------------
// sliding_anagram_window_counter_top
// Counts text windows that are letter permutations of a loaded pattern.
// ----------------------------------------------------------------------------
module sliding_anagram_window_counter_top #(
  parameter int WINDOW_MAX = saw_pkg::WINDOW_MAX_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [saw_pkg::LEN_W-1:0] cfg_data_i,
  input  logic                      push,
  input  saw_pkg::in_item_t         in_item_i,
  output logic                      full,
  input  logic                      pop,
  output logic                      empty,
  output saw_pkg::res_t             res_o
);

  import saw_pkg::*;

  logic [LEN_W-1:0] len_q, len_d;
  op_item_t         mid_item;
  logic             mid_empty, mid_pop;

  // store the window length already clamped to 1..WINDOW_MAX
  always_comb begin
    len_d = len_q;
    if (cfg_we_i) begin
      if (cfg_data_i == '0) begin
        len_d = LEN_W'(1);
      end else if (int'(cfg_data_i) > WINDOW_MAX) begin
        len_d = LEN_W'(WINDOW_MAX);
      end else begin
        len_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1);
    end else begin
      len_q <= len_d;
    end
  end

  saw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_item_i   (in_item_i),
    .full        (full),
    .mid_pop_i   (mid_pop),
    .mid_item_o  (mid_item),
    .mid_empty_o (mid_empty)
  );

  saw_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .len_i       (len_q),
    .mid_item_i  (mid_item),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .pop         (pop),
    .empty       (empty),
    .res_o       (res_o)
  );

endmodule

[tb/sv/tb_sliding_anagram_window_counter_top.sv]
// ----------------------------------------------------------------------------
// tb_sliding_anagram_window_counter_top
// Self-checking bench for the sliding window anagram counter. Items go in
// through the push/full queue port; a local model of both histograms, the
// ring of recent text and the match counter predicts one result per item,
// which is compared field by field with what leaves through empty/pop.
// Covers reset defaults, length clamping, window count bounds after length
// changes, result back-pressure and random pattern/text episodes.
// ----------------------------------------------------------------------------
module tb_sliding_anagram_window_counter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import saw_pkg::*;

  localparam int          CLK_PERIOD    = 8;
  localparam int          WINDOW_DEPTH  = WINDOW_MAX_DEF;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          PRINT_CAP     = 40;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [LEN_W-1:0]    cfg_data_i;
  logic                push;
  in_item_t            in_item_i;
  logic                full;
  logic                pop;
  logic                empty;
  res_t                res_o;

  // local copy of the counter state
  logic [HIST_W-1:0]   pat_hist [ALPHABET_SIZE];
  logic [HIST_W-1:0]   win_hist [ALPHABET_SIZE];
  logic [CHAR_W-1:0]   recent_text [WINDOW_DEPTH];
  logic [LEN_W-1:0]    text_count;
  int unsigned         ring_pos;
  logic [COUNT_W-1:0]  match_total;
  logic [LEN_W-1:0]    window_len;

  res_t                pending_outcomes [$];
  int unsigned         mismatch_count;
  int unsigned         cycle_count;
  bit                  sender_idles;
  bit                  receiver_idles;
  int unsigned         hold_request;
  int unsigned         pop_wait;

  sliding_anagram_window_counter_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .res_o      (res_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int letter_index(input logic [CHAR_W-1:0] ch);
    if (ch >= CH_LC_A && ch <= CH_LC_Z) return int'(ch - CH_LC_A);
    if (ch >= CH_UC_A && ch <= CH_UC_Z) return int'(ch - CH_UC_A) + LOWER_COUNT;
    return -1;
  endfunction

  function automatic int unsigned active_length();
    if (window_len == '0) return 1;
    if (int'(window_len) > WINDOW_DEPTH) return WINDOW_DEPTH;
    return int'(window_len);
  endfunction

  function automatic void clear_prediction();
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      pat_hist[i] = '0;
      win_hist[i] = '0;
    end
    text_count  = '0;
    ring_pos    = 0;
    match_total = '0;
  endfunction

  function automatic res_t anagram_outcome(input logic [1:0] kind, input logic [CHAR_W-1:0] ch);
    res_t        r;
    int unsigned span;
    int          slot;
    int          old_slot;
    int unsigned old_idx;
    bit          same;
    span = active_length();
    slot = letter_index(ch);
    r    = '0;
    if (kind == KIND_CLEAR) begin
      clear_prediction();
      return r;
    end
    if (kind == KIND_PATTERN) begin
      if (slot >= 0 && pat_hist[slot] != HIST_MAX) pat_hist[slot]++;
    end else if (kind == KIND_TEXT) begin
      // the byte span places back drops out of the window
      if (text_count >= span) begin
        old_idx  = (ring_pos + WINDOW_DEPTH - span) % WINDOW_DEPTH;
        old_slot = letter_index(recent_text[old_idx]);
        if (old_slot >= 0 && win_hist[old_slot] != '0) win_hist[old_slot]--;
      end
      recent_text[ring_pos] = ch;
      ring_pos = (ring_pos + 1) % WINDOW_DEPTH;
      if (slot >= 0 && win_hist[slot] != HIST_MAX) win_hist[slot]++;
      if (text_count != SEEN_MAX) text_count++;
      if (text_count >= span) begin
        same = 1'b1;
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
          if (win_hist[i] != pat_hist[i]) same = 1'b0;
        end
        if (same) begin
          r.is_match = 1'b1;
          if (match_total != COUNT_MAX) match_total++;
        end
      end
    end
    r.window_full = (text_count >= span);
    r.match_count = match_total;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [COUNT_W-1:0] got,
                               input logic [COUNT_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("%0t: mismatch on %s, got %0h expected %0h", $realtime, what, got, want);
    end
  endtask

  // one item transfer, with an optional gap in front of it
  task automatic send_item(input logic [1:0] kind, input logic [CHAR_W-1:0] ch);
    int gap;
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push                <= 1'b1;
    in_item_i.kind      <= kind;
    in_item_i.char_byte <= ch;
    do @(posedge clk_i); while (full);
    pending_outcomes.push_back(anagram_outcome(kind, ch));
  endtask

  task automatic send_run(input logic [1:0] kind, input logic [CHAR_W-1:0] ch,
                          input int unsigned count);
    repeat (count) send_item(kind, ch);
  endtask

  // register write only once the block has drained
  task automatic write_window_length(input logic [LEN_W-1:0] value);
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_data_i <= value;
    cfg_we_i   <= 1'b1;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    window_len = value;
  endtask

  function automatic logic [CHAR_W-1:0] random_letter();
    int unsigned r;
    r = $urandom_range(0, ALPHABET_SIZE - 1);
    if (r < LOWER_COUNT) return CH_LC_A + CHAR_W'(r);
    return CH_UC_A + CHAR_W'(r - LOWER_COUNT);
  endfunction

  function automatic logic [CHAR_W-1:0] random_byte();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // window length is 1 out of reset; letter boundaries and every kind
  task automatic test_reset_defaults();
    send_item(KIND_TEXT, "A");
    send_item(KIND_PATTERN, "a");
    send_item(KIND_TEXT, "a");
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_PATTERN, 8'hFF);
    send_item(KIND_TEXT, "a");
    send_item(KIND_UNUSED, "b");
    send_item(KIND_TEXT, 8'h60);
    send_item(KIND_TEXT, 8'h7B);
    send_item(KIND_TEXT, 8'h40);
    send_item(KIND_TEXT, 8'h5B);
    send_item(KIND_TEXT, 8'h80);
    send_item(KIND_TEXT, "z");
    send_item(KIND_CLEAR, 8'hFF);
    send_item(KIND_PATTERN, "Z");
    send_item(KIND_TEXT, "Z");
    send_item(KIND_TEXT, "z");
    send_item(KIND_UNUSED, 8'h7F);
    send_item(KIND_PATTERN, "z");
    send_item(KIND_TEXT, "Z");
  endtask

  // both length clamps, and the window count floor after length changes
  task automatic test_histogram_limits();
    write_window_length(13'h1FFF);
    send_item(KIND_CLEAR, 8'h00);
    send_run(KIND_PATTERN, "a", 8);
    send_run(KIND_TEXT, "a", 8);
    // shrinking mid-stream leaves the older letters counted
    write_window_length(13'd0);
    send_run(KIND_TEXT, ".", 4);
    send_run(KIND_TEXT, "b", 8);
    // growing mid-stream lets uncounted letters leave, the count stops at zero
    write_window_length(13'd8);
    send_run(KIND_TEXT, ".", 12);
    send_run(KIND_TEXT, "a", 10);
  endtask

  task automatic test_result_backpressure();
    logic [CHAR_W-1:0] letters [3];
    letters[0] = "a";
    letters[1] = "b";
    letters[2] = "c";
    write_window_length(13'd3);
    send_item(KIND_CLEAR, 8'h2A);
    for (int i = 0; i < 3; i++) send_item(KIND_PATTERN, letters[i]);
    hold_request = 80;
    repeat (40) send_item(KIND_TEXT, letters[$urandom_range(0, 2)]);
  endtask

  task automatic test_random_episodes(input int unsigned target);
    int unsigned       sent;
    int unsigned       span;
    int unsigned       n_text;
    int unsigned       r;
    logic [LEN_W-1:0]  value;
    logic [CHAR_W-1:0] letters [3];
    sent = 0;
    while (sent < target) begin
      if (sent >= target - target / 6) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end
      r = $urandom_range(0, 19);
      if (r < 12) value = LEN_W'($urandom_range(1, 6));
      else if (r < 17) value = LEN_W'($urandom_range(7, 32));
      else if (r == 17) value = LEN_W'($urandom_range(0, 8191));
      else if (r == 18) value = '0;
      else value = LEN_W'($urandom_range(4096, 8191));
      write_window_length(value);
      // now and then the length changes without a clear
      if ($urandom_range(0, 4) != 0) begin
        send_item(KIND_CLEAR, random_byte());
        sent++;
      end
      for (int i = 0; i < 3; i++) letters[i] = random_letter();
      span = active_length();
      if (span > 48) span = 4;
      for (int i = 0; i < span; i++) begin
        send_item(KIND_PATTERN, letters[$urandom_range(0, 2)]);
        sent++;
      end
      n_text = 2 * span + $urandom_range(2, 24);
      for (int i = 0; i < n_text; i++) begin
        r = $urandom_range(0, 39);
        if (r < 33) send_item(KIND_TEXT, letters[$urandom_range(0, 2)]);
        else if (r < 37) send_item(KIND_TEXT, random_byte());
        else if (r == 37) send_item(KIND_PATTERN, random_byte());
        else if (r == 38) send_item(KIND_UNUSED, random_byte());
        else send_item(KIND_CLEAR, random_byte());
        if (r != 38) sent++;
      end
    end
  endtask

  // result side: random stalls plus the long hold-off on request
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      pop_wait     = hold_request;
      hold_request = 0;
    end
    if (pop_wait != 0) begin
      pop <= 1'b0;
      pop_wait--;
    end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      pop_wait = $urandom_range(0, 5);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("unexpected result transfer", res_o.match_count, '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (res_o.window_full !== want.window_full)
          flag_mismatch("window_full", COUNT_W'(res_o.window_full),
                        COUNT_W'(want.window_full));
        if (res_o.is_match !== want.is_match)
          flag_mismatch("is_match", COUNT_W'(res_o.is_match), COUNT_W'(want.is_match));
        if (res_o.match_count !== want.match_count)
          flag_mismatch("match_count", res_o.match_count, want.match_count);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    push           = 1'b0;
    pop            = 1'b0;
    in_item_i      = '0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = '0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    hold_request   = 0;
    pop_wait       = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    window_len     = LEN_W'(1);
    clear_prediction();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_histogram_limits();
    test_result_backpressure();
    test_random_episodes(1150);

    @(negedge clk_i);
    push <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/saw_pkg.sv
hw/rtl/saw_fifo.sv
hw/rtl/saw_front.sv
hw/rtl/saw_hist.sv
hw/rtl/saw_back.sv
hw/rtl/sliding_anagram_window_counter_top.sv
tb/sv/tb_sliding_anagram_window_counter_top.sv
